[design/pcbd_pkg.sv]
// Shared types and constants for the pulse-count backlight dimmer.
package pcbd_pkg;

    localparam int LevelW = 5;
    localparam int TickW  = 16;
    localparam int PlowW  = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    localparam logic [LevelW-1:0] LEVEL_MAX = LevelW'(16);

    // register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] REG_DISABLE_HOLD   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_INITIAL_ENABLE = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TURN_ON        = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TDIS           = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_PULSE_LOW      = 3'd4;

    // reset values of the timing registers
    localparam logic [TickW-1:0] RST_DISABLE_HOLD   = 16'd250;
    localparam logic [TickW-1:0] RST_INITIAL_ENABLE = 16'd25000;
    localparam logic [TickW-1:0] RST_TURN_ON        = 16'd300;
    localparam logic [TickW-1:0] RST_TDIS           = 16'd200;
    localparam logic [PlowW-1:0] RST_PULSE_LOW      = 8'd1;

    typedef struct packed {
        logic              kind;
        logic [LevelW-1:0] level;
        logic              display_on;
    } t_in_item;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic rejected;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_REQ_ON,
        CMD_REQ_OFF
    } t_cmd_op;

    // classified item as held between front and back
    typedef struct packed {
        t_cmd_op           op;
        logic [LevelW-1:0] level;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HOLD,
        PH_ENABLE,
        PH_TDIS,
        PH_PLOW,
        PH_PHIGH
    } t_phase;

endpackage

[design/pcbd_front.sv]
// Front end: classifies incoming items and holds them in a two-entry queue.
module pcbd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pcbd_pkg::t_in_item i_in_item,
    output logic               o_cmd_valid,
    output pcbd_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_take
);

    pcbd_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    pcbd_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    // clamp the level and sort the item by kind
    always_comb begin
        w_cmd.level = (i_in_item.level > pcbd_pkg::LEVEL_MAX) ? pcbd_pkg::LEVEL_MAX
                                                              : i_in_item.level;
        priority if (!i_in_item.kind) begin
            w_cmd.op = pcbd_pkg::CMD_TICK;
        end else if (i_in_item.display_on) begin
            w_cmd.op = pcbd_pkg::CMD_REQ_ON;
        end else begin
            w_cmd.op = pcbd_pkg::CMD_REQ_OFF;
        end
    end

    assign full        = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/pcbd_back.sv]
// Back end: timing registers and the phase sequencer that drives the pin.
module pcbd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [pcbd_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [pcbd_pkg::CfgDataW-1:0]      i_cfg_data,
    input  logic                               i_cmd_valid,
    input  pcbd_pkg::t_cmd                     i_cmd,
    output logic                               o_cmd_take,
    output logic                               o_res_valid,
    output pcbd_pkg::t_out_item                o_res,
    input  logic                               i_res_full
);

    logic [pcbd_pkg::TickW-1:0]  r_disable_hold;
    logic [pcbd_pkg::TickW-1:0]  r_initial_enable;
    logic [pcbd_pkg::TickW-1:0]  r_turn_on;
    logic [pcbd_pkg::TickW-1:0]  r_tdis;
    logic [pcbd_pkg::PlowW-1:0]  r_pulse_low;

    pcbd_pkg::t_phase             r_phase, n_phase;
    logic                         r_pin, n_pin;
    logic [pcbd_pkg::TickW-1:0]   r_timer, n_timer;
    logic [pcbd_pkg::LevelW-1:0]  r_pulses, n_pulses;
    logic [pcbd_pkg::LevelW-1:0]  r_prev, n_prev;
    logic [pcbd_pkg::LevelW-1:0]  r_pending, n_pending;
    logic                         r_enabled, n_enabled;

    logic                         w_go;
    logic                         w_rej;
    logic                         w_after_enable;
    logic                         w_next_pulse;
    logic [pcbd_pkg::LevelW-1:0]  w_np_pulses;

    assign w_go        = i_cmd_valid && !i_res_full;
    assign o_cmd_take  = w_go;
    assign o_res_valid = w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disable_hold   <= pcbd_pkg::RST_DISABLE_HOLD;
            r_initial_enable <= pcbd_pkg::RST_INITIAL_ENABLE;
            r_turn_on        <= pcbd_pkg::RST_TURN_ON;
            r_tdis           <= pcbd_pkg::RST_TDIS;
            r_pulse_low      <= pcbd_pkg::RST_PULSE_LOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pcbd_pkg::REG_DISABLE_HOLD:   r_disable_hold   <= i_cfg_data;
                pcbd_pkg::REG_INITIAL_ENABLE: r_initial_enable <= i_cfg_data;
                pcbd_pkg::REG_TURN_ON:        r_turn_on        <= i_cfg_data;
                pcbd_pkg::REG_TDIS:           r_tdis           <= i_cfg_data;
                pcbd_pkg::REG_PULSE_LOW:      r_pulse_low      <= i_cfg_data[pcbd_pkg::PlowW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_pin          = r_pin;
        n_timer        = r_timer;
        n_pulses       = r_pulses;
        n_prev         = r_prev;
        n_pending      = r_pending;
        n_enabled      = r_enabled;
        w_rej          = 1'b0;
        w_after_enable = 1'b0;
        w_next_pulse   = 1'b0;
        w_np_pulses    = r_pulses;

        if (w_go) begin
            if (i_cmd.op == pcbd_pkg::CMD_TICK) begin
                if (r_phase != pcbd_pkg::PH_IDLE) begin
                    if (r_timer > pcbd_pkg::TickW'(1)) begin
                        n_timer = r_timer - pcbd_pkg::TickW'(1);
                    end else begin
                        // last tick of the phase: move on
                        unique case (r_phase)
                            pcbd_pkg::PH_ENABLE: w_after_enable = 1'b1;
                            pcbd_pkg::PH_TDIS:   w_next_pulse   = 1'b1;
                            pcbd_pkg::PH_PLOW: begin
                                n_phase = pcbd_pkg::PH_PHIGH;
                                n_pin   = 1'b1;
                                n_timer = r_turn_on;
                            end
                            pcbd_pkg::PH_PHIGH: begin
                                w_np_pulses  = r_pulses - pcbd_pkg::LevelW'(1);
                                w_next_pulse = 1'b1;
                            end
                            default: begin
                                n_prev   = r_pending;
                                n_pulses = '0;
                                n_timer  = '0;
                                n_phase  = pcbd_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
            end else if (r_phase != pcbd_pkg::PH_IDLE) begin
                w_rej = 1'b1;
            end else if (i_cmd.op == pcbd_pkg::CMD_REQ_ON && i_cmd.level != r_prev) begin
                n_pending = i_cmd.level;
                priority if (i_cmd.level == '0) begin
                    n_phase = pcbd_pkg::PH_HOLD;
                    n_pin   = 1'b0;
                    n_timer = r_disable_hold;
                end else if (r_prev == '0) begin
                    n_phase   = pcbd_pkg::PH_ENABLE;
                    n_pin     = 1'b1;
                    n_timer   = r_enabled ? r_turn_on : r_initial_enable;
                    n_enabled = 1'b1;
                end else begin
                    w_after_enable = 1'b1;
                end
            end
        end

        // rising level: TDIS gap then count down from the top; falling level: pulse down from the previous level
        if (w_after_enable) begin
            if (r_prev < n_pending) begin
                n_pulses = pcbd_pkg::LEVEL_MAX - n_pending + pcbd_pkg::LevelW'(1);
                n_phase  = pcbd_pkg::PH_TDIS;
                n_pin    = 1'b0;
                n_timer  = r_tdis;
            end else begin
                w_np_pulses  = r_prev - n_pending;
                w_next_pulse = 1'b1;
            end
        end

        if (w_next_pulse) begin
            if (w_np_pulses == '0) begin
                n_prev   = n_pending;
                n_pulses = '0;
                n_timer  = '0;
                n_phase  = pcbd_pkg::PH_IDLE;
            end else begin
                n_pulses = w_np_pulses;
                n_phase  = pcbd_pkg::PH_PLOW;
                n_pin    = 1'b0;
                n_timer  = {{(pcbd_pkg::TickW-pcbd_pkg::PlowW){1'b0}}, r_pulse_low};
            end
        end

        o_res.pin_level = n_pin;
        o_res.busy_res  = (n_phase != pcbd_pkg::PH_IDLE);
        o_res.rejected  = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pcbd_pkg::PH_IDLE;
            r_pin     <= 1'b0;
            r_timer   <= '0;
            r_pulses  <= '0;
            r_prev    <= '0;
            r_pending <= '0;
            r_enabled <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pin     <= n_pin;
            r_timer   <= n_timer;
            r_pulses  <= n_pulses;
            r_prev    <= n_prev;
            r_pending <= n_pending;
            r_enabled <= n_enabled;
        end
    end

endmodule

[design/pcbd_outq.sv]
// Result queue: two entries between the sequencer and the output side.
module pcbd_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  pcbd_pkg::t_out_item i_res,
    output logic                o_full,
    output logic                empty,
    input  logic                pop,
    output pcbd_pkg::t_out_item o_out_item
);

    pcbd_pkg::t_out_item r_mem [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                w_wr;
    logic                w_rd;

    assign o_full     = (r_count == 2'd2);
    assign empty      = (r_count == 2'd0);
    assign o_out_item = r_mem[r_rd_ptr];
    assign w_wr       = i_wr && !o_full;
    assign w_rd       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/pulse_count_backlight_dimmer.sv]
// Pulse-count backlight dimmer: input queue, phase sequencer, result queue.
// An item is written into the input queue, then its result into the result queue, after which empty goes low.
// Throughput: one item per cycle while neither queue stalls; the sequencer updates its state once per item.
// Each side stalls on its own through a two-entry queue at input and output.
// Reset (synchronous, active low): queues empty, pin low, idle, timing registers at defaults.
module pulse_count_backlight_dimmer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  pcbd_pkg::t_in_item            i_in_item,
    output logic                          empty,
    input  logic                          pop,
    output pcbd_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcbd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [pcbd_pkg::CfgDataW-1:0] i_cfg_data
);

    logic                w_cmd_valid;
    pcbd_pkg::t_cmd      w_cmd;
    logic                w_cmd_take;
    logic                w_res_valid;
    pcbd_pkg::t_out_item w_res;
    logic                w_res_full;

    assign o_cfg_ready = 1'b1;

    pcbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    pcbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    pcbd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_res_valid),
        .i_res      (w_res),
        .o_full     (w_res_full),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

endmodule
